// ===== hdl/tamb_pkg.sv =====
// Shared types, widths and codes for the timesliced audio mix buffer.
`timescale 1ns / 1ps

package tamb_pkg;

    // Field widths of the item channels
    localparam int SLICE_W  = 32;
    localparam int VALUE_W  = 16;
    localparam int CHAN_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;

    // Configuration register widths and reset values
    localparam int SPS_W = 7;
    localparam int CC_W  = 4;
    localparam logic [SPS_W-1:0] SPS_RESET = 7'd48;
    localparam logic [CC_W-1:0]  CC_RESET  = 4'd2;

    // Register index decoded from paddr[2]
    localparam logic REG_SAMPLES  = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    // Default geometry of the sample store
    localparam int RING_SLICES_DEF       = 16;
    localparam int MAX_CHANNELS_DEF      = 8;
    localparam int MAX_SLICE_SAMPLES_DEF = 64;

    // Full-scale level used for saturation
    localparam int FULL_SCALE = 32767;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LATE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAR   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted item
        logic check;     // classify the item and issue the store read
        logic exec;      // update the store and state, load the result register
        logic clr_step;  // zero one store entry of the clearing pass
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;     // clearing pass is at its last entry
        logic drain_clear;  // the executing pull drains a slot that holds mixes
    } stat_t;

endpackage

// ===== hdl/tamb_in_if.sv =====
// Input item channel: mix and pull requests.
`timescale 1ns / 1ps

interface tamb_in_if;
    import tamb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [SLICE_W-1:0]         slice_time;
    logic [CHAN_W-1:0]          channel;
    logic [INDEX_W-1:0]         sample_index;
    logic signed [VALUE_W-1:0]  sample_value;

    modport source (
        output valid, kind, slice_time, channel, sample_index, sample_value,
        input  ready
    );

    modport sink (
        input  valid, kind, slice_time, channel, sample_index, sample_value,
        output ready
    );
endinterface

// ===== hdl/tamb_out_if.sv =====
// Result item channel: status and mixed sample.
`timescale 1ns / 1ps

interface tamb_out_if;
    import tamb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  mixed_value;
    logic [SLICE_W-1:0]         out_slice_time;
    logic [CHAN_W-1:0]          out_channel;
    logic                       last_of_slice;

    modport source (
        output valid, status, mixed_value, out_slice_time, out_channel, last_of_slice,
        input  ready
    );

    modport sink (
        input  valid, status, mixed_value, out_slice_time, out_channel, last_of_slice,
        output ready
    );
endinterface

// ===== hdl/tamb_cfg.sv =====
// APB register block holding samples_per_slice and channel_count.
`timescale 1ns / 1ps

module tamb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [tamb_pkg::SPS_W-1:0]  samples_per_slice,
    output logic [tamb_pkg::CC_W-1:0]   channel_count
);
    import tamb_pkg::*;

    logic [SPS_W-1:0] sps_reg;
    logic [SPS_W-1:0] sps_next;
    logic [CC_W-1:0]  cc_reg;
    logic [CC_W-1:0]  cc_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        sps_next = sps_reg;
        cc_next  = cc_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_SAMPLES:  sps_next = pwdata[SPS_W-1:0];
                REG_CHANNELS: cc_next  = pwdata[CC_W-1:0];
                default:      sps_next = sps_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg <= SPS_RESET;
            cc_reg  <= CC_RESET;
        end
        else
        begin
            sps_reg <= sps_next;
            cc_reg  <= cc_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SAMPLES:  prdata = 32'(sps_reg);
            REG_CHANNELS: prdata = 32'(cc_reg);
            default:      prdata = '0;
        endcase
    end

    assign samples_per_slice = sps_reg;
    assign channel_count     = cc_reg;

endmodule

// ===== hdl/tamb_ctrl.sv =====
// Controller state machine: sequences clear, accept, check and execute.
`timescale 1ns / 1ps

module tamb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tamb_pkg::stat_t   stat,
    output tamb_pkg::cmd_t    cmd
);
    import tamb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register may be reloaded when empty or when taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.clr_step = (state_reg == S_CLEAR);
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.check    = (state_reg == S_CHECK);
        cmd.exec     = (state_reg == S_EXEC) && out_free;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = stat.drain_clear ? S_CLEAR : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // The store read issued while checking is consumed in the execute state, which the check state always moves to.
    a_check_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |=> (state_reg == S_EXEC))
        else $error("check state not followed by execute");

    // Draining a written slot blocks new items until the slot is zeroed.
    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.drain_clear) |=> (state_reg == S_CLEAR && !in_ready))
        else $error("drained slot not cleared");

    // A new result only appears out of the execute state.
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC))
        else $error("result raised outside execute");

    // The clearing pass runs to its last entry.
    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !stat.clr_done) |=> (state_reg == S_CLEAR))
        else $error("clearing pass left early");

endmodule

// ===== hdl/tamb_dp.sv =====
// Datapath: sample store, read pointers, slot bookkeeping and result register.
`timescale 1ns / 1ps

module tamb_dp #(
    parameter int RING_SLICES       = tamb_pkg::RING_SLICES_DEF,
    parameter int MAX_CHANNELS      = tamb_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SLICE_SAMPLES = tamb_pkg::MAX_SLICE_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tamb_pkg::cmd_t                      cmd,
    output tamb_pkg::stat_t                     stat,
    input  logic [tamb_pkg::SPS_W-1:0]          samples_per_slice,
    input  logic [tamb_pkg::CC_W-1:0]           channel_count,
    input  logic                                kind,
    input  logic [tamb_pkg::SLICE_W-1:0]        slice_time,
    input  logic [tamb_pkg::CHAN_W-1:0]         channel,
    input  logic [tamb_pkg::INDEX_W-1:0]        sample_index,
    input  logic signed [tamb_pkg::VALUE_W-1:0] sample_value,
    output logic [tamb_pkg::STATUS_W-1:0]       status,
    output logic signed [tamb_pkg::VALUE_W-1:0] mixed_value,
    output logic [tamb_pkg::SLICE_W-1:0]        out_slice_time,
    output logic [tamb_pkg::CHAN_W-1:0]         out_channel,
    output logic                                last_of_slice
);
    import tamb_pkg::*;

    localparam int SLW   = (RING_SLICES > 1) ? $clog2(RING_SLICES) : 1;
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW    = (MAX_SLICE_SAMPLES > 1) ? $clog2(MAX_SLICE_SAMPLES) : 1;
    localparam int AW    = SLW + CHW + SW;
    localparam int DEPTH = RING_SLICES * (2 ** (CHW + SW));

    localparam logic [SLW:0]       RING_W   = (SLW + 1)'(RING_SLICES);
    localparam logic [SLW-1:0]     SLOT_TOP = SLW'(RING_SLICES - 1);
    localparam logic [SPS_W-1:0]   SPS_MAX  = SPS_W'(MAX_SLICE_SAMPLES);
    localparam logic [CC_W-1:0]    CC_MAX   = CC_W'(MAX_CHANNELS);
    localparam logic [AW-1:0]      ADDR_TOP = AW'(DEPTH - 1);
    localparam logic signed [VALUE_W:0] SAT_HI = (VALUE_W + 1)'(FULL_SCALE);
    localparam logic signed [VALUE_W:0] SAT_LO = -SAT_HI;

    // Sample store, zeroed by the clearing passes
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Captured item
    logic                      it_kind_reg;
    logic [SLICE_W-1:0]        it_time_reg;
    logic [CHAN_W-1:0]         it_ch_reg;
    logic [INDEX_W-1:0]        it_si_reg;
    logic signed [VALUE_W-1:0] it_val_reg;

    // Read position and slot bookkeeping
    logic [SLICE_W-1:0]     read_slice_reg, read_slice_next;
    logic [SLW-1:0]         read_slot_reg, read_slot_next;
    logic [CHW-1:0]         read_ch_reg, read_ch_next;
    logic [SW-1:0]          read_sample_reg, read_sample_next;
    logic [SLICE_W-1:0]     newest_reg, newest_next;
    logic                   any_reg, any_next;
    logic [RING_SLICES-1:0] written_reg, written_next;

    // Clearing pass address range
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] clr_end_reg, clr_end_next;

    // Classification captured in the check cycle
    logic [STATUS_W-1:0] chk_status_reg;
    logic                chk_mix_ok_reg;
    logic                chk_pull_ok_reg;
    logic                chk_rd_ok_reg;
    logic                chk_written_reg;
    logic [SLW-1:0]      chk_slot_reg;
    logic [AW-1:0]       chk_addr_reg;

    // Check-cycle logic
    logic [SPS_W-1:0]   eff_sps;
    logic [CC_W-1:0]    eff_cc;
    logic [SLICE_W-1:0] diff;
    logic               started;
    logic               late;
    logic               far;
    logic               mix_in_area;
    logic               pull_in_area;
    logic               empty;
    logic [SLW:0]       slot_sum;
    logic [SLW-1:0]     mix_slot;
    logic [SLW-1:0]     slot_sel;
    logic [AW-1:0]      rd_addr;
    logic [STATUS_W-1:0] status_calc;

    // Execute-cycle logic
    logic signed [VALUE_W:0]   sum_wide;
    logic signed [VALUE_W-1:0] sat_val;
    logic                      samp_wrap;
    logic                      ch_wrap;
    logic                      drain;

    always_comb
    begin
        if (samples_per_slice == '0)
            eff_sps = SPS_W'(1);
        else if (samples_per_slice > SPS_MAX)
            eff_sps = SPS_MAX;
        else
            eff_sps = samples_per_slice;

        if (channel_count == '0)
            eff_cc = CC_W'(1);
        else if (channel_count > CC_MAX)
            eff_cc = CC_MAX;
        else
            eff_cc = channel_count;
    end

    always_comb
    begin
        started      = (read_ch_reg != '0) || (read_sample_reg != '0);
        diff         = it_time_reg - read_slice_reg;
        late         = (it_time_reg < read_slice_reg) ||
                       ((it_time_reg == read_slice_reg) && started);
        far          = diff >= SLICE_W'(RING_SLICES);
        mix_in_area  = (CC_W'(it_ch_reg) < eff_cc) && (SPS_W'(it_si_reg) < eff_sps);
        pull_in_area = (CC_W'(read_ch_reg) < eff_cc) && (SPS_W'(read_sample_reg) < eff_sps);
        empty        = !any_reg || (read_slice_reg > newest_reg);

        // The mix slot follows the read slot; the distance is below the ring size.
        slot_sum = {1'b0, read_slot_reg} + {1'b0, diff[SLW-1:0]};
        if (slot_sum >= RING_W)
            mix_slot = SLW'(slot_sum - RING_W);
        else
            mix_slot = slot_sum[SLW-1:0];

        if (it_kind_reg)
        begin
            slot_sel    = read_slot_reg;
            rd_addr     = {read_slot_reg, read_ch_reg, read_sample_reg};
            status_calc = empty ? STATUS_EMPTY : STATUS_OK;
        end
        else
        begin
            slot_sel = mix_slot;
            rd_addr  = {mix_slot, it_ch_reg[CHW-1:0], it_si_reg[SW-1:0]};
            if (late)
                status_calc = STATUS_LATE;
            else if (far)
                status_calc = STATUS_FAR;
            else
                status_calc = STATUS_OK;
        end
    end

    always_comb
    begin
        sum_wide = {rd_data_reg[VALUE_W-1], rd_data_reg} + {it_val_reg[VALUE_W-1], it_val_reg};
        if (sum_wide > SAT_HI)
            sat_val = SAT_HI[VALUE_W-1:0];
        else if (sum_wide < SAT_LO)
            sat_val = SAT_LO[VALUE_W-1:0];
        else
            sat_val = sum_wide[VALUE_W-1:0];

        samp_wrap = (SPS_W'(read_sample_reg) + SPS_W'(1)) >= eff_sps;
        ch_wrap   = (CC_W'(read_ch_reg) + CC_W'(1)) >= eff_cc;
        drain     = chk_pull_ok_reg && samp_wrap && ch_wrap;
    end

    assign stat.clr_done    = (clr_cnt_reg == clr_end_reg);
    assign stat.drain_clear = drain && chk_written_reg;

    // Store port: clearing writes, accumulation writes, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.exec && chk_mix_ok_reg)
            mem[chk_addr_reg] <= sat_val;
        if (cmd.check)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_kind_reg <= kind;
            it_time_reg <= slice_time;
            it_ch_reg   <= channel;
            it_si_reg   <= sample_index;
            it_val_reg  <= sample_value;
        end
        if (cmd.check)
        begin
            chk_status_reg  <= status_calc;
            chk_mix_ok_reg  <= !it_kind_reg && !late && !far && mix_in_area;
            chk_pull_ok_reg <= it_kind_reg && !empty;
            chk_rd_ok_reg   <= pull_in_area;
            chk_written_reg <= written_reg[slot_sel];
            chk_slot_reg    <= slot_sel;
            chk_addr_reg    <= rd_addr;
        end
    end

    always_comb
    begin
        read_slice_next  = read_slice_reg;
        read_slot_next   = read_slot_reg;
        read_ch_next     = read_ch_reg;
        read_sample_next = read_sample_reg;
        newest_next      = newest_reg;
        any_next         = any_reg;
        written_next     = written_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_end_next     = clr_end_reg;

        if (cmd.clr_step)
            clr_cnt_next = clr_cnt_reg + AW'(1);

        if (cmd.exec)
        begin
            if (chk_mix_ok_reg)
            begin
                written_next[chk_slot_reg] = 1'b1;
                if (!any_reg || (it_time_reg > newest_reg))
                    newest_next = it_time_reg;
                any_next = 1'b1;
            end
            if (chk_pull_ok_reg)
            begin
                if (samp_wrap)
                begin
                    read_sample_next = '0;
                    if (ch_wrap)
                    begin
                        read_ch_next                = '0;
                        written_next[read_slot_reg] = 1'b0;
                        read_slice_next             = read_slice_reg + SLICE_W'(1);
                        // The slice count wraps to zero, whose slot is zero too.
                        if ((read_slice_reg == '1) || (read_slot_reg == SLOT_TOP))
                            read_slot_next = '0;
                        else
                            read_slot_next = read_slot_reg + SLW'(1);
                    end
                    else
                    begin
                        read_ch_next = read_ch_reg + CHW'(1);
                    end
                end
                else
                begin
                    read_sample_next = read_sample_reg + SW'(1);
                end
            end
            if (drain && chk_written_reg)
            begin
                clr_cnt_next = {read_slot_reg, {(CHW + SW){1'b0}}};
                clr_end_next = {read_slot_reg, {(CHW + SW){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_slice_reg  <= '0;
            read_slot_reg   <= '0;
            read_ch_reg     <= '0;
            read_sample_reg <= '0;
            newest_reg      <= '0;
            any_reg         <= 1'b0;
            written_reg     <= '0;
            clr_cnt_reg     <= '0;
            clr_end_reg     <= ADDR_TOP;
        end
        else
        begin
            read_slice_reg  <= read_slice_next;
            read_slot_reg   <= read_slot_next;
            read_ch_reg     <= read_ch_next;
            read_sample_reg <= read_sample_next;
            newest_reg      <= newest_next;
            any_reg         <= any_next;
            written_reg     <= written_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_end_reg     <= clr_end_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status <= chk_status_reg;
            if (chk_mix_ok_reg)
                mixed_value <= sat_val;
            else if (chk_pull_ok_reg && chk_rd_ok_reg)
                mixed_value <= rd_data_reg;
            else
                mixed_value <= '0;
            out_slice_time <= it_kind_reg ? read_slice_reg : it_time_reg;
            out_channel    <= it_kind_reg ? CHAN_W'(read_ch_reg) : it_ch_reg;
            last_of_slice  <= drain;
        end
    end

endmodule

// ===== hdl/timesliced_audio_mix_buffer.sv =====
// Top level of the timesliced audio mix buffer.
//
//   Channel   Dir  Handshake             Content
//   items     in   valid/ready           kind, slice_time, channel, sample_index, sample_value
//   results   out  valid/ready           status, mixed_value, out_slice_time, out_channel,
//                                        last_of_slice
//   APB       in   psel/penable, pready  samples_per_slice at 0x0, channel_count at 0x4
//
// Each item passes in turn through accept, store read and classification, then the
// read-modify-write of the store and the load of the result register.
// A pull that drains a slice holding mixes then zeroes that slot of the store,
// one entry per cycle, 2^(clog2(MAX_CHANNELS)+clog2(MAX_SLICE_SAMPLES)) entries (512).
// After reset the whole store, all RING_SLICES slots, is zeroed first, during which no item
// is taken; register writes are taken at any time.
// A new item is taken while a result still waits; execution stalls only when
// the result register is still full.
`timescale 1ns / 1ps

module timesliced_audio_mix_buffer #(
    parameter int RING_SLICES       = tamb_pkg::RING_SLICES_DEF,
    parameter int MAX_CHANNELS      = tamb_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SLICE_SAMPLES = tamb_pkg::MAX_SLICE_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tamb_in_if.sink     items,
    tamb_out_if.source  results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tamb_pkg::*;

    logic [SPS_W-1:0] samples_per_slice;
    logic [CC_W-1:0]  channel_count;
    cmd_t             cmd;
    stat_t            stat;

    tamb_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .samples_per_slice (samples_per_slice),
        .channel_count     (channel_count)
    );

    tamb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tamb_dp #(
        .RING_SLICES       (RING_SLICES),
        .MAX_CHANNELS      (MAX_CHANNELS),
        .MAX_SLICE_SAMPLES (MAX_SLICE_SAMPLES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .samples_per_slice (samples_per_slice),
        .channel_count     (channel_count),
        .kind              (items.kind),
        .slice_time        (items.slice_time),
        .channel           (items.channel),
        .sample_index      (items.sample_index),
        .sample_value      (items.sample_value),
        .status            (results.status),
        .mixed_value       (results.mixed_value),
        .out_slice_time    (results.out_slice_time),
        .out_channel       (results.out_channel),
        .last_of_slice     (results.last_of_slice)
    );

endmodule

// ===== verif/timesliced_audio_mix_buffer_tb.sv =====
// Self-checking testbench for the timesliced audio mix buffer.
`timescale 1ns / 1ps

module timesliced_audio_mix_buffer_tb;
    import tamb_pkg::*;

    typedef enum logic {
        KIND_MIX  = 1'b0,
        KIND_PULL = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [SLICE_W-1:0]        slice;
        logic [CHAN_W-1:0]         chan;
        logic                      last;
    } mix_outcome_t;

    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_CYCLES   = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tamb_in_if  request_ch ();
    tamb_out_if outcome_ch ();

    timesliced_audio_mix_buffer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (request_ch),
        .results (outcome_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the ring, read position and registers.
    logic signed [VALUE_W-1:0] mix_mem [RING_SLICES_DEF][MAX_CHANNELS_DEF][MAX_SLICE_SAMPLES_DEF];
    logic [RING_SLICES_DEF-1:0] slot_live = '0;
    logic [SLICE_W-1:0] rd_slice  = '0;
    int                 rd_chan   = 0;
    int                 rd_samp   = 0;
    logic [SLICE_W-1:0] newest    = '0;
    bit                 any_mixed = 1'b0;
    logic [SPS_W-1:0]   cfg_sps   = SPS_RESET;
    logic [CC_W-1:0]    cfg_cc    = CC_RESET;

    mix_outcome_t mix_outcomes[$];
    int  err_count     = 0;
    bit  gaps_on       = 1'b1;
    int  sink_hold_req = 0;

    function automatic int active_samples();
        if (cfg_sps == 0)
            return 1;
        if (cfg_sps > MAX_SLICE_SAMPLES_DEF)
            return MAX_SLICE_SAMPLES_DEF;
        return int'(cfg_sps);
    endfunction

    function automatic int active_channels();
        if (cfg_cc == 0)
            return 1;
        if (cfg_cc > MAX_CHANNELS_DEF)
            return MAX_CHANNELS_DEF;
        return int'(cfg_cc);
    endfunction

    function automatic mix_outcome_t predict_outcome(
        input req_kind_t                 kind,
        input logic [SLICE_W-1:0]        t,
        input logic [CHAN_W-1:0]         ch,
        input logic [INDEX_W-1:0]        si,
        input logic signed [VALUE_W-1:0] v
    );
        mix_outcome_t o;
        int          spp;
        int          cc;
        int          sum;
        int unsigned slot;
        bit          started;
        spp = active_samples();
        cc  = active_channels();
        o   = '0;
        if (kind == KIND_PULL)
        begin
            o.slice = rd_slice;
            o.chan  = rd_chan[CHAN_W-1:0];
            if (!any_mixed || rd_slice > newest)
            begin
                o.status = STATUS_EMPTY;
                return o;
            end
            slot = rd_slice % RING_SLICES_DEF;
            // A position left out of range by a register change reads as silence.
            if (slot_live[slot] && rd_chan < cc && rd_samp < spp)
                o.value = mix_mem[slot][rd_chan][rd_samp];
            if (rd_samp + 1 >= spp)
            begin
                rd_samp = 0;
                if (rd_chan + 1 >= cc)
                begin
                    o.last          = 1'b1;
                    rd_chan         = 0;
                    slot_live[slot] = 1'b0;
                    rd_slice        = rd_slice + 1;
                end
                else
                    rd_chan++;
            end
            else
                rd_samp++;
            return o;
        end
        o.slice = t;
        o.chan  = ch;
        started = (rd_chan != 0) || (rd_samp != 0);
        if (t < rd_slice || (t == rd_slice && started))
            o.status = STATUS_LATE;
        else if (t - rd_slice >= RING_SLICES_DEF)
            o.status = STATUS_FAR;
        else if (ch < cc && si < spp)
        begin
            slot = t % RING_SLICES_DEF;
            if (!slot_live[slot])
            begin
                for (int c = 0; c < MAX_CHANNELS_DEF; c++)
                    for (int s = 0; s < MAX_SLICE_SAMPLES_DEF; s++)
                        mix_mem[slot][c][s] = '0;
                slot_live[slot] = 1'b1;
            end
            sum = int'(mix_mem[slot][ch][si]) + int'(v);
            if (sum > FULL_SCALE)
                sum = FULL_SCALE;
            if (sum < -FULL_SCALE)
                sum = -FULL_SCALE;
            mix_mem[slot][ch][si] = sum[VALUE_W-1:0];
            if (!any_mixed || t > newest)
                newest = t;
            any_mixed = 1'b1;
            o.value   = sum[VALUE_W-1:0];
        end
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : outcome_check
        mix_outcome_t want;
        if (outcome_ch.valid === 1'b1 && outcome_ch.ready === 1'b1)
        begin
            if (mix_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d value %0d",
                         $time, outcome_ch.status, outcome_ch.mixed_value);
                err_count++;
            end
            else
            begin
                want = mix_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(outcome_ch.status));
                check_field("mixed_value", 32'(want.value), 32'(outcome_ch.mixed_value));
                check_field("out_slice_time", want.slice, outcome_ch.out_slice_time);
                check_field("out_channel", 32'(want.chan), 32'(outcome_ch.out_channel));
                check_field("last_of_slice", 32'(want.last), 32'(outcome_ch.last_of_slice));
            end
        end
    end

    // Result side: random short stalls, or one long hold-off when requested.
    initial
    begin : result_sink
        int stall;
        outcome_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req != 0)
            begin
                stall         = sink_hold_req;
                sink_hold_req = 0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 4);
            else
                stall = 0;
            if (stall != 0)
            begin
                outcome_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            outcome_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(
        input req_kind_t                 kind,
        input logic [SLICE_W-1:0]        t,
        input logic [CHAN_W-1:0]         ch,
        input logic [INDEX_W-1:0]        si,
        input logic signed [VALUE_W-1:0] v
    );
        request_ch.valid        <= 1'b1;
        request_ch.kind         <= kind;
        request_ch.slice_time   <= t;
        request_ch.channel      <= ch;
        request_ch.sample_index <= si;
        request_ch.sample_value <= v;
        @(posedge clk);
        while (request_ch.ready !== 1'b1)
            @(posedge clk);
        mix_outcomes.push_back(predict_outcome(kind, t, ch, si, v));
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_mix(input logic [SLICE_W-1:0] t, input logic [CHAN_W-1:0] ch,
                            input logic [INDEX_W-1:0] si, input logic signed [VALUE_W-1:0] v);
        send_item(KIND_MIX, t, ch, si, v);
    endtask

    task automatic send_pull();
        send_item(KIND_PULL, $urandom, CHAN_W'($urandom), INDEX_W'($urandom),
                  VALUE_W'($urandom));
    endtask

    function automatic logic signed [VALUE_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh8001;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly mixes near the read position and pulls, with some late and random noise.
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_item(req_kind_t'($urandom_range(0, 1)), $urandom, CHAN_W'($urandom),
                      INDEX_W'($urandom), VALUE_W'($urandom));
        else if (pick < 12)
            send_mix(rd_slice - $urandom_range(0, 2),
                     CHAN_W'($urandom_range(0, active_channels() - 1)),
                     INDEX_W'($urandom_range(0, active_samples() - 1)), random_level());
        else if (pick < 55)
            send_mix(rd_slice + $urandom_range(0, 5),
                     CHAN_W'($urandom_range(0, active_channels() - 1)),
                     INDEX_W'($urandom_range(0, active_samples() - 1)), random_level());
        else
            send_pull();
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (reg_sel == REG_SAMPLES)
            cfg_sps = data[SPS_W-1:0];
        else
            cfg_cc = data[CC_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Returning the bus to idle before the task ends keeps a following write from driving the bus in the same step.
        @(posedge clk);
    endtask

    // Waits for every pending result, then covers a possible slot clearing pass.
    task automatic settle_block();
        request_ch.valid <= 1'b0;
        while (mix_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_saturation_and_drops();
        send_pull();
        send_mix(32'd0, 3'd1, 6'd47, 16'sh7FFF);
        send_mix(32'd0, 3'd1, 6'd47, 16'sd1);
        send_mix(32'd0, 3'd2, 6'd0, 16'sd100);
        send_mix(32'd0, 3'd0, 6'd48, 16'sd100);
        send_mix(32'd16, 3'd0, 6'd0, 16'sd5);
        send_mix(32'hFFFF_FFFF, 3'd7, 6'd63, 16'sh8000);
        send_mix(32'd1, 3'd0, 6'd0, 16'sh8000);
        send_mix(32'd1, 3'd0, 6'd0, -16'sd1);
        send_mix(32'd15, 3'd1, 6'd5, 16'sh1234);
        send_pull();
        send_mix(32'd0, 3'd0, 6'd0, 16'sd9);
    endtask

    task automatic test_geometry_limits();
        settle_block();
        apb_write(REG_SAMPLES, 32'd0);
        apb_write(REG_CHANNELS, 32'd0);
        // The read position now lies past the single-sample slice.
        send_pull();
        send_pull();
        send_mix(32'd0, 3'd0, 6'd0, 16'sd3);
        send_mix(32'd2, 3'd0, 6'd63, 16'sd7);
        send_mix(32'd2, 3'd1, 6'd0, 16'sd7);
        settle_block();
        apb_write(REG_SAMPLES, 32'd127);
        apb_write(REG_CHANNELS, 32'd15);
        send_mix(32'd2, 3'd7, 6'd63, 16'shAAAA);
        send_mix(32'd2, 3'd7, 6'd63, 16'sh5555);
        send_pull();
        send_mix(32'd17, 3'd0, 6'd0, 16'sh4000);
        send_mix(32'd18, 3'd0, 6'd0, 16'sh4000);
    endtask

    task automatic test_output_backpressure();
        settle_block();
        apb_write(REG_SAMPLES, 32'd2);
        apb_write(REG_CHANNELS, 32'd2);
        sink_hold_req = HOLD_CYCLES;
        repeat (30) send_random_item();
    endtask

    task automatic test_random_traffic();
        int sps_val;
        int cc_val;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin sps_val = 1; cc_val = 1; end
                1: begin sps_val = 3; cc_val = 2; end
                2: begin sps_val = 8; cc_val = 1; end
                3: begin sps_val = 2; cc_val = 8; end
                default:
                begin
                    sps_val = $urandom_range(0, 127);
                    cc_val  = $urandom_range(0, 15);
                end
            endcase
            settle_block();
            apb_write(REG_SAMPLES, sps_val);
            apb_write(REG_CHANNELS, cc_val);
            repeat (65) send_random_item();
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        settle_block();
        apb_write(REG_SAMPLES, 32'd4);
        apb_write(REG_CHANNELS, 32'd3);
        repeat (40) send_random_item();
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        request_ch.valid        <= 1'b0;
        request_ch.kind         <= KIND_MIX;
        request_ch.slice_time   <= '0;
        request_ch.channel      <= '0;
        request_ch.sample_index <= '0;
        request_ch.sample_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_saturation_and_drops();
        test_geometry_limits();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        settle_block();
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("%0t: timeout with %0d results pending", $time, mix_outcomes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
